### src/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, opcodes and saturation helper for the vec3 fixed-point ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int Q_W           = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STAGES   = 32;  // one root bit per stage
  localparam int DIV_STAGES    = 32;  // one quotient bit per stage
  localparam int SAT_W         = 72;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [Q_W-1:0]        mag_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    CMD_VADD  = 4'd0,
    CMD_VSUB  = 4'd1,
    CMD_VMUL  = 4'd2,
    CMD_SADD  = 4'd3,
    CMD_SSUB  = 4'd4,
    CMD_SMUL  = 4'd5,
    CMD_SDIV  = 4'd6,
    CMD_DOT   = 4'd7,
    CMD_CROSS = 4'd8,
    CMD_MAG   = 4'd9,
    CMD_NORM  = 4'd10,
    CMD_EQ    = 4'd11,
    CMD_NE    = 4'd12
  } cmd_t;

  // sideband that rides along the root and quotient pipelines
  typedef struct packed {
    cmd_t       cmd;
    q_t [2:0]   v;
    q_t         rs;
    logic       cmp;
    mag_t [2:0] amag;
    logic [2:0] aneg;
    mag_t       smag;
    logic       sneg;
    mag_t       root;
  } ctx_t;

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t res;
    if (v > SAT_W'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < SAT_W'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = q_t'(v[Q_W-1:0]);
    end
    return res;
  endfunction

endpackage

### src/vfa_ifs.sv
// ----------------------------------------------------------------------------
// vfa_ifs
// Valid/ready channels for the command word and the result word.
// ----------------------------------------------------------------------------
interface vfa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic signed [31:0] bz;
  logic signed [31:0] operand_scalar;

  modport source (output valid, command, ax, ay, az, bx, by, bz, operand_scalar,
                  input ready);
  modport sink (input valid, command, ax, ay, az, bx, by, bz, operand_scalar,
                output ready);
endinterface

interface vfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic signed [31:0] rz;
  logic signed [31:0] result_scalar;
  logic               compare_true;
  logic               error_flag;

  modport source (output valid, rx, ry, rz, result_scalar, compare_true, error_flag,
                  input ready);
  modport sink (input valid, rx, ry, rz, result_scalar, compare_true, error_flag,
                output ready);
endinterface

### src/vec3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu
// Three-lane Q-format vector ALU. Accepts one command word per clock and
// returns one result word per command, in order. Every command passes through
// the 32-stage square-root pipeline followed by the 33-stage divider
// (normalize needs the root before it can divide); all commands take the same
// path so results never reorder. Every stage shares
// one advance enable: the block takes a word whenever its output register is
// empty or being read, so with the consumer ready it runs at one word/cycle.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu import vfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vfa_in_if.sink    in_ch,
  vfa_out_if.source out_ch
);

  localparam int TW         = 64 - FRAC_BITS;
  localparam int PIPE_DEPTH = 4 + SQRT_STAGES + DIV_STAGES + 1;

  logic adv;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;

  // input word
  cmd_t cmd1_r;
  q_t   a1_r [3];
  q_t   b1_r [3];
  q_t   s1_r;

  cmd_t cmd2_r, cmd3_r;
  logic cmp2_r, cmp3_r;
  mag_t smag2_r, smag3_r;
  logic sneg2_r, sneg3_r;
  logic a_eq_b;

  q_t                   lane_v  [3];
  logic signed [TW-1:0] lane_t  [3];
  logic [62:0]          lane_sq [3];
  mag_t                 lane_am [3];
  logic                 lane_an [3];

  ctx_t        ctx4_nxt, ctx4_r;
  logic [63:0] sumsq4_r;
  q_t          dot_sum;

  mag_t root_w;
  ctx_t ctx_sq_r [SQRT_STAGES];
  ctx_t ctx_dv_r [DIV_STAGES+1];
  ctx_t ctx_dv_nxt;
  ctx_t cf;
  mag_t dmag_w;
  logic dneg_w;

  q_t   quo_w [3];
  logic dz_w  [3];

  q_t   r_nxt  [3];
  q_t   rs_nxt;
  logic err_nxt;
  q_t   rx_r, ry_r, rz_r, rs_r;
  logic cmp_r, err_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= cmd_t'(in_ch.command);
      a1_r[0] <= in_ch.ax;
      a1_r[1] <= in_ch.ay;
      a1_r[2] <= in_ch.az;
      b1_r[0] <= in_ch.bx;
      b1_r[1] <= in_ch.by;
      b1_r[2] <= in_ch.bz;
      s1_r    <= in_ch.operand_scalar;
    end
  end

  assign a_eq_b = (a1_r[0] == b1_r[0]) && (a1_r[1] == b1_r[1]) && (a1_r[2] == b1_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r  <= cmd1_r;
      cmp2_r  <= ((cmd1_r == CMD_EQ) && a_eq_b) || ((cmd1_r == CMD_NE) && !a_eq_b);
      smag2_r <= mag_t'(s1_r[Q_W-1] ? -s1_r : s1_r);
      sneg2_r <= s1_r[Q_W-1];
      cmd3_r  <= cmd2_r;
      cmp3_r  <= cmp2_r;
      smag3_r <= smag2_r;
      sneg3_r <= sneg2_r;
    end
  end

  // cross lane i: a[i+1]*b[i+2] - a[i+2]*b[i+1]
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vfa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (adv),
      .cmd  (cmd1_r),
      .a    (a1_r[i]),
      .b    (b1_r[i]),
      .s    (s1_r),
      .xa0  (a1_r[(i+1)%3]),
      .xb0  (b1_r[(i+2)%3]),
      .xa1  (a1_r[(i+2)%3]),
      .xb1  (b1_r[(i+1)%3]),
      .v    (lane_v[i]),
      .term (lane_t[i]),
      .sq   (lane_sq[i]),
      .amag (lane_am[i]),
      .aneg (lane_an[i])
    );
  end

  // merge: dot sum and sum of squares
  assign dot_sum = sat_q(SAT_W'(lane_t[0]) + SAT_W'(lane_t[1]) + SAT_W'(lane_t[2]));

  always_comb begin
    ctx4_nxt.cmd  = cmd3_r;
    for (int i = 0; i < 3; i++) begin
      ctx4_nxt.v[i]    = lane_v[i];
      ctx4_nxt.amag[i] = lane_am[i];
      ctx4_nxt.aneg[i] = lane_an[i];
    end
    ctx4_nxt.rs   = (cmd3_r == CMD_DOT) ? dot_sum : '0;
    ctx4_nxt.cmp  = cmp3_r;
    ctx4_nxt.smag = smag3_r;
    ctx4_nxt.sneg = sneg3_r;
    ctx4_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4_r   <= ctx4_nxt;
      sumsq4_r <= 64'(lane_sq[0]) + 64'(lane_sq[1]) + 64'(lane_sq[2]);
    end
  end

  vfa_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sumsq4_r),
    .root (root_w)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_sq_r[0] <= ctx4_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        ctx_sq_r[k] <= ctx_sq_r[k-1];
      end
    end
  end

  always_comb begin
    ctx_dv_nxt      = ctx_sq_r[SQRT_STAGES-1];
    ctx_dv_nxt.root = root_w;
  end

  assign dmag_w = (ctx_dv_nxt.cmd == CMD_NORM) ? root_w : ctx_dv_nxt.smag;
  assign dneg_w = (ctx_dv_nxt.cmd == CMD_NORM) ? 1'b0 : ctx_dv_nxt.sneg;

  for (genvar i = 0; i < 3; i++) begin : g_div
    vfa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (adv),
      .amag (ctx_dv_nxt.amag[i]),
      .aneg (ctx_dv_nxt.aneg[i]),
      .dmag (dmag_w),
      .dneg (dneg_w),
      .quo  (quo_w[i]),
      .dz   (dz_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_dv_r[0] <= ctx_dv_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        ctx_dv_r[k] <= ctx_dv_r[k-1];
      end
    end
  end

  assign cf = ctx_dv_r[DIV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_nxt[i] = cf.v[i];
    end
    rs_nxt  = cf.rs;
    err_nxt = 1'b0;
    case (cf.cmd)
      CMD_SDIV: begin
        for (int i = 0; i < 3; i++) begin
          r_nxt[i] = quo_w[i];
        end
        err_nxt = dz_w[0];
      end
      CMD_NORM: begin
        // zero-length vector: flag and all-zero components
        for (int i = 0; i < 3; i++) begin
          r_nxt[i] = dz_w[0] ? '0 : quo_w[i];
        end
        err_nxt = dz_w[0];
      end
      CMD_MAG: rs_nxt = (cf.root > mag_t'(Q_MAX)) ? Q_MAX : q_t'(cf.root);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r  <= r_nxt[0];
      ry_r  <= r_nxt[1];
      rz_r  <= r_nxt[2];
      rs_r  <= rs_nxt;
      cmp_r <= cf.cmp;
      err_r <= err_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rx            = rx_r;
  assign out_ch.ry            = ry_r;
  assign out_ch.rz            = rz_r;
  assign out_ch.result_scalar = rs_r;
  assign out_ch.compare_true  = cmp_r;
  assign out_ch.error_flag    = err_r;

endmodule

### src/vfa_lane.sv
// ----------------------------------------------------------------------------
// vfa_lane
// One vector component: add/sub, two multipliers, product reduction.
// ----------------------------------------------------------------------------
module vfa_lane import vfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TW = 64 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  cmd_t                 cmd,
  input  q_t                   a,
  input  q_t                   b,
  input  q_t                   s,
  input  q_t                   xa0,
  input  q_t                   xb0,
  input  q_t                   xa1,
  input  q_t                   xb1,
  output q_t                   v,
  output logic signed [TW-1:0] term,
  output logic [62:0]          sq,
  output mag_t                 amag,
  output logic                 aneg
);

  q_t                 m0a, m0b, addend;
  logic               do_sub;
  logic signed [32:0] sum;
  logic signed [63:0] p0, p1;

  cmd_t               cmd2_r;
  logic signed [63:0] p0_r, p1_r;
  q_t                 simp_r;
  mag_t               amag2_r;
  logic               aneg2_r;

  logic signed [TW-1:0] q0, q1;
  q_t                   v_nxt;
  q_t                   v_r;
  logic signed [TW-1:0] term_r;
  logic [62:0]          sq_r;
  mag_t                 amag_r;
  logic                 aneg_r;

  always_comb begin
    m0a    = a;
    m0b    = a;   // squares for magnitude and normalize
    addend = s;
    do_sub = 1'b0;
    case (cmd) inside
      CMD_VMUL, CMD_DOT: m0b = b;
      CMD_SMUL:          m0b = s;
      CMD_CROSS: begin
        m0a = xa0;
        m0b = xb0;
      end
      CMD_VADD: addend = b;
      CMD_VSUB: begin
        addend = b;
        do_sub = 1'b1;
      end
      CMD_SSUB: do_sub = 1'b1;
      default: ;
    endcase
  end

  assign sum = do_sub ? 33'(a) - 33'(addend) : 33'(a) + 33'(addend);
  assign p0  = m0a * m0b;
  assign p1  = xa1 * xb1;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r  <= cmd;
      p0_r    <= p0;
      p1_r    <= p1;
      simp_r  <= sat_q(SAT_W'(sum));
      amag2_r <= mag_t'(a[Q_W-1] ? -a : a);
      aneg2_r <= a[Q_W-1];
    end
  end

  // arithmetic right shift of the product is the floor
  assign q0 = $signed(p0_r[63:FRAC_BITS]);
  assign q1 = $signed(p1_r[63:FRAC_BITS]);

  always_comb begin
    case (cmd2_r) inside
      CMD_VADD, CMD_VSUB, CMD_SADD, CMD_SSUB: v_nxt = simp_r;
      CMD_VMUL, CMD_SMUL:                     v_nxt = sat_q(SAT_W'(q0));
      CMD_CROSS:                              v_nxt = sat_q(SAT_W'(q0) - SAT_W'(q1));
      default:                                v_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      term_r <= q0;
      sq_r   <= p0_r[62:0];
      amag_r <= amag2_r;
      aneg_r <= aneg2_r;
    end
  end

  assign v    = v_r;
  assign term = term_r;
  assign sq   = sq_r;
  assign amag = amag_r;
  assign aneg = aneg_r;

endmodule

### src/vfa_isqrt.sv
// ----------------------------------------------------------------------------
// vfa_isqrt
// Pipelined integer square root, 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module vfa_isqrt import vfa_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output mag_t        root
);

  logic [32:0] rem_r  [SQRT_STAGES];
  mag_t        root_r [SQRT_STAGES];
  logic [63:0] rad_r  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stg
    logic [32:0] rem_in;
    mag_t        root_in;
    logic [63:0] rad_in;
    logic [34:0] part;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign part  = {rem_in, rad_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= trial) begin
          rem_r[k]  <= 33'(part - trial);
          root_r[k] <= {root_in[Q_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= part[32:0];
          root_r[k] <= {root_in[Q_W-2:0], 1'b0};
        end
        rad_r[k] <= {rad_in[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

### src/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div
// Pipelined restoring divider: (|a| << FRAC_BITS) / d, signed, saturated.
// ----------------------------------------------------------------------------
module vfa_div import vfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  mag_t amag,
  input  logic aneg,
  input  mag_t dmag,
  input  logic dneg,
  output q_t   quo,
  output logic dz
);

  localparam int DW = Q_W + FRAC_BITS;

  typedef struct packed {
    logic dz;
    logic ovf;
    logic neg;
    logic aneg;
    logic anz;
  } dflags_t;

  logic [DW-1:0]        dvd;
  logic [FRAC_BITS-1:0] hi;
  mag_t                 hi_ext;
  dflags_t              fl_nxt;

  mag_t    rem_r [DIV_STAGES+1];
  mag_t    lo_r  [DIV_STAGES+1];
  mag_t    quo_r [DIV_STAGES+1];
  mag_t    dm_r  [DIV_STAGES+1];
  dflags_t fl_r  [DIV_STAGES+1];

  mag_t    q;
  dflags_t fl;

  assign dvd    = {amag, {FRAC_BITS{1'b0}}};
  assign hi     = dvd[DW-1:Q_W];
  assign hi_ext = {{(Q_W-FRAC_BITS){1'b0}}, hi};

  // quotient at or above 2^32 is caught here, so 32 iterations suffice
  always_comb begin
    fl_nxt.dz   = (dmag == '0);
    fl_nxt.ovf  = (hi_ext >= dmag);
    fl_nxt.neg  = aneg ^ dneg;
    fl_nxt.aneg = aneg;
    fl_nxt.anz  = (amag != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext;
      lo_r[0]  <= dvd[Q_W-1:0];
      quo_r[0] <= '0;
      dm_r[0]  <= dmag;
      fl_r[0]  <= fl_nxt;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stg
    logic [Q_W:0] part;
    assign part = {rem_r[k-1], lo_r[k-1][Q_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= {1'b0, dm_r[k-1]}) begin
          rem_r[k] <= Q_W'(part - {1'b0, dm_r[k-1]});
          quo_r[k] <= {quo_r[k-1][Q_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= part[Q_W-1:0];
          quo_r[k] <= {quo_r[k-1][Q_W-2:0], 1'b0};
        end
        lo_r[k] <= {lo_r[k-1][Q_W-2:0], 1'b0};
        dm_r[k] <= dm_r[k-1];
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  assign q  = quo_r[DIV_STAGES];
  assign fl = fl_r[DIV_STAGES];

  always_comb begin
    if (fl.dz) begin
      quo = fl.aneg ? Q_MIN : (fl.anz ? Q_MAX : '0);
    end else if (fl.ovf) begin
      quo = fl.neg ? Q_MIN : Q_MAX;
    end else if (fl.neg) begin
      quo = (q > mag_t'(Q_MIN)) ? Q_MIN : q_t'(-q);
    end else begin
      quo = (q > mag_t'(Q_MAX)) ? Q_MAX : q_t'(q);
    end
  end

  assign dz = fl.dz;

endmodule

### src/vfa_chk.sv
// ----------------------------------------------------------------------------
// vfa_chk
// Port-level checks for the vec3 ALU, bound to the top level.
// ----------------------------------------------------------------------------
module vfa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rx,
  input logic [31:0] ry,
  input logic [31:0] rz,
  input logic [31:0] result_scalar,
  input logic        compare_true,
  input logic        error_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(rx) && $stable(ry) && $stable(rz)
                                && $stable(result_scalar) && $stable(compare_true)
                                && $stable(error_flag))
    else $error("result word changed while stalled");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && compare_true |-> rx == '0 && ry == '0 && rz == '0
                                  && result_scalar == '0 && !error_flag)
    else $error("compare word carries other results");

  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_flag |-> result_scalar == '0 && !compare_true)
    else $error("error word carries scalar or compare result");

endmodule

bind vec3_fixed_point_alu vfa_chk u_vfa_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .rx            (out_ch.rx),
  .ry            (out_ch.ry),
  .rz            (out_ch.rz),
  .result_scalar (out_ch.result_scalar),
  .compare_true  (out_ch.compare_true),
  .error_flag    (out_ch.error_flag)
);

### tb/sv/vec3_fixed_point_alu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_checker
// Watches the command and result channels, computes the expected result word
// for every accepted command and compares each result word against it.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_checker import vfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vfa_in_if    in_ch,
  vfa_out_if   out_ch,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    q_t   rx;
    q_t   ry;
    q_t   rz;
    q_t   rs;
    logic cmp;
    logic err;
  } vres_t;

  vres_t expected_q[$];

  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift gives floor, matching the products' rounding
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint fx_div_mag(input longint a, input longint unsigned dm,
                                        input logic dneg);
    longint unsigned am, q;
    logic neg;
    am  = (a < 0) ? longint'(-a) : a;
    q   = (am << FRAC_BITS) / dm;
    neg = (a < 0) != dneg;
    if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r, bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic vres_t vec_predict(input logic [3:0] cmd, input longint a[3],
                                        input longint b[3], input longint s);
    vres_t e;
    longint r[3];
    longint unsigned m, sq;
    e = '0;
    r = '{0, 0, 0};
    case (cmd)
      CMD_VADD: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + b[i]);
      CMD_VSUB: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - b[i]);
      CMD_VMUL: for (int i = 0; i < 3; i++) r[i] = clamp_q(fx_mul(a[i], b[i]));
      CMD_SADD: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + s);
      CMD_SSUB: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - s);
      CMD_SMUL: for (int i = 0; i < 3; i++) r[i] = clamp_q(fx_mul(a[i], s));
      CMD_SDIV: begin
        for (int i = 0; i < 3; i++) begin
          if (s == 0) begin
            e.err = 1'b1;
            r[i] = (a[i] > 0) ? 64'sd2147483647 : ((a[i] < 0) ? -64'sd2147483648 : 0);
          end else begin
            r[i] = fx_div_mag(a[i], (s < 0) ? -s : s, s < 0);
          end
        end
      end
      CMD_DOT: e.rs = q_t'(clamp_q(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1])
                                   + fx_mul(a[2], b[2])));
      CMD_CROSS: begin
        r[0] = clamp_q(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
        r[1] = clamp_q(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
        r[2] = clamp_q(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
      end
      CMD_MAG, CMD_NORM: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
        m = root_floor(sq);
        if (cmd == CMD_MAG) begin
          e.rs = (m > 64'd2147483647) ? Q_MAX : q_t'(m);
        end else if (m == 0) begin
          e.err = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) r[i] = fx_div_mag(a[i], m, 1'b0);
        end
      end
      CMD_EQ: e.cmp = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      CMD_NE: e.cmp = !((a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]));
      default: ;
    endcase
    e.rx = q_t'(r[0]);
    e.ry = q_t'(r[1]);
    e.rz = q_t'(r[2]);
    return e;
  endfunction

  always @(posedge clk) begin
    longint a[3], b[3];
    vres_t e, got;
    if (!rst_n) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        a[0] = in_ch.ax;
        a[1] = in_ch.ay;
        a[2] = in_ch.az;
        b[0] = in_ch.bx;
        b[1] = in_ch.by;
        b[2] = in_ch.bz;
        expected_q.push_back(vec_predict(in_ch.command, a, b, longint'(in_ch.operand_scalar)));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.rx, out_ch.ry, out_ch.rz, out_ch.result_scalar,
                out_ch.compare_true, out_ch.error_flag};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== got) begin
            $display("%0t: mismatch expected rx=%h ry=%h rz=%h rs=%h cmp=%b err=%b",
                     $time, e.rx, e.ry, e.rz, e.rs, e.cmp, e.err);
            $display("%0t:          actual   rx=%h ry=%h rz=%h rs=%h cmp=%b err=%b",
                     $time, got.rx, got.ry, got.rz, got.rs, got.cmp, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

### tb/sv/vec3_fixed_point_alu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_test
// Drives directed and random vector commands through the ALU under varying
// sender and receiver stalls; the checker compares every result word.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_test import vfa_pkg::*;;

  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle;
  int   recv_idle;
  int   quiet_cycles;

  vfa_in_if  in_ch();
  vfa_out_if out_ch();

  vec3_fixed_point_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  vec3_fixed_point_alu_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_VADD;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz} = '0;
    in_ch.operand_scalar = '0;
    out_ch.ready = 1'b0;
    send_idle = 25;
    recv_idle = 64;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic q_t pick_q();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return q_t'($urandom_range(2)) - 1;
      4, 5: return q_t'($signed($urandom_range(65535 * 8)) - 65535 * 4);
      default: return q_t'($urandom);
    endcase
  endfunction

  // one command word, held until accepted; valid stays up into the next word
  task automatic send_word(input logic [3:0] cmd, input q_t a[3], input q_t b[3],
                           input q_t s);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.ax <= a[0];
    in_ch.ay <= a[1];
    in_ch.az <= a[2];
    in_ch.bx <= b[0];
    in_ch.by <= b[1];
    in_ch.bz <= b[2];
    in_ch.operand_scalar <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int n);
    q_t a[3], b[3], s;
    logic [3:0] cmd;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = pick_q();
        b[i] = ($urandom_range(3) == 0) ? a[i] : pick_q();
      end
      s = ($urandom_range(15) == 0) ? '0 : pick_q();
      if ($urandom_range(19) == 0) a = '{0, 0, 0};
      cmd = ($urandom_range(29) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      send_word(cmd, a, b, s);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    q_t za[3], mx[3], mn[3], mix[3];
    za  = '{0, 0, 0};
    mx  = '{Q_MAX, Q_MAX, Q_MAX};
    mn  = '{Q_MIN, Q_MIN, Q_MIN};
    mix = '{Q_MAX, Q_MIN, 32'sh0001_8000};
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every command at the extremes, plus divide by zero and zero normalize
    for (int c = 0; c <= 12; c++) send_word(4'(c), mx, mn, Q_MIN);
    send_word(CMD_SDIV, mix, za, '0);
    send_word(CMD_SDIV, za, za, '0);
    send_word(CMD_SDIV, mix, mx, 32'sh0000_0001);
    send_word(CMD_NORM, za, za, '0);
    send_word(CMD_NORM, mix, za, '0);
    send_word(CMD_MAG, mn, za, '0);
    send_word(CMD_DOT, mx, mx, '0);
    send_word(CMD_CROSS, mix, mn, '0);
    send_word(CMD_EQ, mix, mix, '0);
    send_word(CMD_NE, mix, mix, '0);
    send_word(4'd15, mx, mx, Q_MAX);
    send_word(CMD_SMUL, mn, za, Q_MIN);

    // pause until everything is back
    drain();
    send_random(340);
    send_idle = 64;
    recv_idle = 25;
    send_random(340);
    send_idle = 0;
    recv_idle = 0;
    send_random(345);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
